// File: hw/rtl/set_assoc_lru_cache_sim_defines.svh
// Assertion macros shared by the cache simulator RTL.
`ifndef SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_SIM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/slc_pkg.sv
`default_nettype none

package slc_pkg;

	// Default sizes of the line store and address
	localparam int MAX_SET_COUNT_DEF = 256;
	localparam int MAX_WAYS_DEF      = 8;
	localparam int ADDRESS_WIDTH_DEF = 64;

	// Field widths
	localparam int CMD_W        = 2;
	localparam int ADDR_FIELD_W = 64;
	localparam int EV_W         = 2;
	localparam int SET_BITS_W   = 4;
	localparam int BLOCK_BITS_W = 6;
	localparam int WAYS_W       = 4;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 6;

	// Raw set index is at most 15 bits (set_bits is a 4-bit count)
	localparam int IDX_W   = (1 << SET_BITS_W) - 1;
	// Shift amount set_bits + block_bits reaches 78
	localparam int SHAMT_W = 7;
	// Way count before clamping, with room for the clamp value
	localparam int WCNT_W  = WAYS_W + 1;

	// Events per access: hit, or miss with optional eviction, plus the modify hit
	localparam int EV_MAX   = 3;
	localparam int EV_CNT_W = 2;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_LOAD   = 2'd0;
	localparam cmd_t CMD_STORE  = 2'd1;
	localparam cmd_t CMD_MODIFY = 2'd2;

	typedef logic [EV_W-1:0] ev_t;
	localparam ev_t EV_HIT   = 2'd0;
	localparam ev_t EV_MISS  = 2'd1;
	localparam ev_t EV_EVICT = 2'd2;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_SET_BITS   = 2'd0;
	localparam cfg_idx_t REG_BLOCK_BITS = 2'd1;
	localparam cfg_idx_t REG_WAYS       = 2'd2;

	// Queue occupancy seen by producer and consumer
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/slc_fifo.sv
`default_nettype none

module slc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = slc_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output slc_pkg::q_stat_t      stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign pop_data   = slot_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);

	// Store pushed entry
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/slc_front.sv
`default_nettype none

module slc_front #(
	parameter int MAX_SET_COUNT = slc_pkg::MAX_SET_COUNT_DEF,
	parameter int ADDRESS_WIDTH = slc_pkg::ADDRESS_WIDTH_DEF,
	localparam int SET_W   = (MAX_SET_COUNT > 1) ? $clog2(MAX_SET_COUNT) : 1,
	localparam int ENTRY_W = 1 + SET_W + ADDRESS_WIDTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [slc_pkg::CMD_W-1:0]          command,
	input  wire logic [slc_pkg::ADDR_FIELD_W-1:0]   address,
	input  wire logic [slc_pkg::SET_BITS_W-1:0]     set_bits,
	input  wire logic [slc_pkg::BLOCK_BITS_W-1:0]   block_bits,
	input  wire slc_pkg::q_stat_t                   q_stat,
	output logic                                    push,
	output logic      [ENTRY_W-1:0]                 push_data
);

	localparam int IDX_W     = slc_pkg::IDX_W;
	// Reciprocal of the set count, exact for every IDX_W-bit index
	localparam int RED_SHIFT = IDX_W + $clog2(MAX_SET_COUNT) + 1;
	localparam int RECIP_W   = RED_SHIFT + 1;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << RED_SHIFT)
		+ 64'(MAX_SET_COUNT) - 64'd1) / 64'(MAX_SET_COUNT));
	localparam int PROD_W    = IDX_W + RECIP_W;

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_MUL  = 2'd1;
	localparam logic [1:0] F_RED  = 2'd2;

	logic [1:0]               state_q;
	logic [IDX_W-1:0]         idx_q;
	logic [ADDRESS_WIDTH-1:0] tag_q;
	logic                     mod_q;
	logic [PROD_W-1:0]        prod_q;

	logic [ADDRESS_WIDTH-1:0]          addr_m;
	logic [ADDRESS_WIDTH-1:0]          shifted;
	logic [slc_pkg::SHAMT_W-1:0]       shamt;
	logic [IDX_W-1:0]                  idx_mask;
	logic [IDX_W-1:0]                  idx_in;
	logic [ADDRESS_WIDTH-1:0]          tag_in;
	logic [IDX_W-1:0]                  quot;
	logic [IDX_W-1:0]                  quot_c;
	logic [IDX_W-1:0]                  rem_raw;
	logic [IDX_W-1:0]                  rem_fix;
	logic                              accept;

	// Split the address into raw set index and tag
	always_comb begin
		addr_m   = address[ADDRESS_WIDTH-1:0];
		shamt    = slc_pkg::SHAMT_W'(set_bits) + slc_pkg::SHAMT_W'(block_bits);
		shifted  = addr_m >> block_bits;
		idx_mask = (IDX_W'(1) << set_bits) - IDX_W'(1);
		idx_in   = shifted[IDX_W-1:0] & idx_mask;
		tag_in   = addr_m >> shamt;
	end

	// Reduce the raw index modulo the set count
	always_comb begin
		quot    = prod_q[RED_SHIFT +: IDX_W];
		quot_c  = quot * IDX_W'(MAX_SET_COUNT);
		rem_raw = idx_q - quot_c;
		rem_fix = (rem_raw >= IDX_W'(MAX_SET_COUNT)) ? rem_raw - IDX_W'(MAX_SET_COUNT)
			: rem_raw;
	end

	assign push      = (state_q == F_RED) && !q_stat.full;
	assign push_data = {mod_q, rem_fix[SET_W-1:0], tag_q};
	assign in_stall  = !((state_q == F_IDLE) || push);
	assign accept    = in_valid && !in_stall;

	// Capture the classified item
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= idx_in;
			tag_q <= tag_in;
			mod_q <= (command == slc_pkg::CMD_MODIFY);
		end
		if (state_q == F_MUL) begin
			prod_q <= idx_q * RECIP;
		end
	end

	// Sequence accept, multiply, reduce and push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					state_q <= F_RED;
				end
				F_RED: begin
					if (accept) begin
						state_q <= F_MUL;
					end else if (push) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/slc_back.sv
`default_nettype none

module slc_back #(
	parameter int MAX_SET_COUNT = slc_pkg::MAX_SET_COUNT_DEF,
	parameter int MAX_WAYS      = slc_pkg::MAX_WAYS_DEF,
	parameter int ADDRESS_WIDTH = slc_pkg::ADDRESS_WIDTH_DEF,
	localparam int SET_W   = (MAX_SET_COUNT > 1) ? $clog2(MAX_SET_COUNT) : 1,
	localparam int ENTRY_W = 1 + SET_W + ADDRESS_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [slc_pkg::WAYS_W-1:0]    ways_in_use,
	input  wire logic                          flush,
	input  wire slc_pkg::q_stat_t              q_stat,
	output logic                               pop,
	input  wire logic [ENTRY_W-1:0]            pop_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [slc_pkg::EV_W-1:0]      event_res,
	output logic                               last_event
);

	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int AGE_W  = WAY_W;
	localparam int WCNT_W = slc_pkg::WCNT_W;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_EVAL = 2'd1;
	localparam logic [1:0] B_EMIT = 2'd2;

	// Row store: per-way valid, tag and age of every set
	logic [MAX_WAYS-1:0]                    vmem [MAX_SET_COUNT];
	logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] tmem [MAX_SET_COUNT];
	logic [MAX_WAYS-1:0][AGE_W-1:0]         amem [MAX_SET_COUNT];

	// One flop per set; a clear row reads as just after reset
	logic [MAX_SET_COUNT-1:0] set_valid_q;

	logic [1:0]                             state_q;
	logic [MAX_WAYS-1:0]                    rd_valid_q;
	logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] rd_tag_q;
	logic [MAX_WAYS-1:0][AGE_W-1:0]         rd_age_q;
	logic                                   row_ok_q;
	logic [SET_W-1:0]                       set_q;
	logic [ADDRESS_WIDTH-1:0]               tag_q;
	logic                                   mod_q;

	logic                                   out_valid_q;
	slc_pkg::ev_t                           event_q;
	logic                                   last_q;
	slc_pkg::ev_t                           ev_list_q [slc_pkg::EV_MAX];
	logic [slc_pkg::EV_CNT_W-1:0]           ev_cnt_q;
	logic [slc_pkg::EV_CNT_W-1:0]           ev_pos_q;

	logic                                   head_mod;
	logic [SET_W-1:0]                       head_set;
	logic [ADDRESS_WIDTH-1:0]               head_tag;
	logic                                   out_xfer;
	logic                                   issue;

	logic [WCNT_W-1:0]                      ways_raw;
	logic [WCNT_W-1:0]                      ways_eff;
	logic [MAX_WAYS-1:0]                    act;
	logic [MAX_WAYS-1:0]                    cur_valid;
	logic [MAX_WAYS-1:0][AGE_W-1:0]         cur_age;
	logic [MAX_WAYS-1:0]                    hit_vec;
	logic [MAX_WAYS-1:0]                    vic_vec;
	logic [WAY_W-1:0]                       hit_way;
	logic [WAY_W-1:0]                       vic_way;
	logic [WAY_W-1:0]                       t_way;
	logic [AGE_W-1:0]                       t_age;
	logic                                   hit;
	logic                                   evict;
	logic [MAX_WAYS-1:0]                    new_valid;
	logic [MAX_WAYS-1:0][ADDRESS_WIDTH-1:0] new_tag;
	logic [MAX_WAYS-1:0][AGE_W-1:0]         new_age;
	slc_pkg::ev_t                           ev_list [slc_pkg::EV_MAX];
	logic [slc_pkg::EV_CNT_W-1:0]           ev_cnt;

	assign head_mod = pop_data[ENTRY_W-1];
	assign head_set = pop_data[ADDRESS_WIDTH +: SET_W];
	assign head_tag = pop_data[ADDRESS_WIDTH-1:0];

	assign out_xfer = out_valid_q && !out_stall;
	// Start the next access as soon as the last event of the current one transfers
	assign issue    = !q_stat.empty && ((state_q == B_IDLE)
		|| ((state_q == B_EMIT) && out_xfer && last_q));
	assign pop      = issue;

	assign out_valid  = out_valid_q;
	assign event_res  = event_q;
	assign last_event = last_q;

	// Clamp the associativity
	always_comb begin
		ways_raw = WCNT_W'(ways_in_use);
		if (ways_raw == '0) begin
			ways_eff = WCNT_W'(1);
		end else if (ways_raw > WCNT_W'(MAX_WAYS)) begin
			ways_eff = WCNT_W'(MAX_WAYS);
		end else begin
			ways_eff = ways_raw;
		end
	end

	// Look up the row: hit way, or the oldest active way as victim
	always_comb begin
		hit_way = '0;
		vic_way = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			act[w]       = WCNT_W'(w) < ways_eff;
			cur_valid[w] = row_ok_q && rd_valid_q[w];
			cur_age[w]   = row_ok_q ? rd_age_q[w] : AGE_W'(w);
			hit_vec[w]   = act[w] && cur_valid[w] && (rd_tag_q[w] == tag_q);
			vic_vec[w]   = act[w] && (WCNT_W'(cur_age[w]) == ways_eff - WCNT_W'(1));
		end
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (hit_vec[w]) begin
				hit_way = WAY_W'(w);
			end
			if (vic_vec[w]) begin
				vic_way = WAY_W'(w);
			end
		end
		hit   = |hit_vec;
		evict = !hit && cur_valid[vic_way];
		t_way = hit ? hit_way : vic_way;
		t_age = cur_age[t_way];
	end

	// Build the updated row: fill the victim on a miss, make the touched way youngest
	always_comb begin
		new_valid = cur_valid;
		new_tag   = rd_tag_q;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WAY_W'(w) == t_way) begin
				new_age[w] = '0;
			end else if (act[w] && (cur_age[w] < t_age)) begin
				new_age[w] = cur_age[w] + AGE_W'(1);
			end else begin
				new_age[w] = cur_age[w];
			end
		end
		if (!hit) begin
			new_valid[vic_way] = 1'b1;
			new_tag[vic_way]   = tag_q;
		end
	end

	// List the events; the second access of a modify always hits
	always_comb begin
		ev_list[0] = hit ? slc_pkg::EV_HIT : slc_pkg::EV_MISS;
		ev_list[1] = evict ? slc_pkg::EV_EVICT : slc_pkg::EV_HIT;
		ev_list[2] = slc_pkg::EV_HIT;
		ev_cnt     = slc_pkg::EV_CNT_W'(1) + slc_pkg::EV_CNT_W'(evict)
			+ slc_pkg::EV_CNT_W'(mod_q);
	end

	// Read the row and latch the job
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_valid_q <= vmem[head_set];
			rd_tag_q   <= tmem[head_set];
			rd_age_q   <= amem[head_set];
			row_ok_q   <= set_valid_q[head_set];
			set_q      <= head_set;
			tag_q      <= head_tag;
			mod_q      <= head_mod;
		end
	end

	// Write the row back
	always_ff @(posedge clk) begin
		if (state_q == B_EVAL) begin
			vmem[set_q] <= new_valid;
			tmem[set_q] <= new_tag;
			amem[set_q] <= new_age;
		end
	end

	// Load events and step through them at the output register
	always_ff @(posedge clk) begin
		if (state_q == B_EVAL) begin
			ev_list_q <= ev_list;
			ev_cnt_q  <= ev_cnt;
			event_q   <= ev_list[0];
			last_q    <= (ev_cnt == slc_pkg::EV_CNT_W'(1));
		end else if ((state_q == B_EMIT) && out_xfer && !last_q) begin
			event_q <= ev_list_q[ev_pos_q];
			last_q  <= ((ev_pos_q + slc_pkg::EV_CNT_W'(1)) == ev_cnt_q);
		end
	end

	// Control: sequencer, output valid, set valid flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			ev_pos_q    <= '0;
			set_valid_q <= '0;
		end else begin
			if (flush) begin
				set_valid_q <= '0;
			end else if (state_q == B_EVAL) begin
				set_valid_q[set_q] <= 1'b1;
			end
			unique case (state_q)
				B_IDLE: begin
					if (issue) begin
						state_q <= B_EVAL;
					end
				end
				B_EVAL: begin
					out_valid_q <= 1'b1;
					ev_pos_q    <= slc_pkg::EV_CNT_W'(1);
					state_q     <= B_EMIT;
				end
				B_EMIT: begin
					if (out_xfer) begin
						if (last_q) begin
							out_valid_q <= 1'b0;
							state_q     <= issue ? B_EVAL : B_IDLE;
						end else begin
							ev_pos_q <= ev_pos_q + slc_pkg::EV_CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/set_assoc_lru_cache_sim.sv
// Channel  Dir  Handshake              Payload
// cfg      in   cfg_we                 cfg_index, cfg_data
// in       in   in_valid / in_stall    command, address
// out      out  out_valid / out_stall  event_res, last_event
// Front: capture and split, then the reciprocal multiply that folds the set index onto
//   the set count, then reduce and push; a new item is taken as the last one is pushed.
// Back: read the row, then evaluate and write back, then one event per cycle while
//   out_stall is low; each item yields n events, n = 1 to 3.
// Reset clears one valid flop per set at once; no clearing pass. A ways_in_use
//   write clears them the same way. out_stall holds the output register and the back sequencer.
`default_nettype none

`include "set_assoc_lru_cache_sim_defines.svh"

module set_assoc_lru_cache_sim #(
	parameter int MAX_SET_COUNT = slc_pkg::MAX_SET_COUNT_DEF,
	parameter int MAX_WAYS      = slc_pkg::MAX_WAYS_DEF,
	parameter int ADDRESS_WIDTH = slc_pkg::ADDRESS_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [slc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [slc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [slc_pkg::CMD_W-1:0]         command,
	input  wire logic [slc_pkg::ADDR_FIELD_W-1:0]  address,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [slc_pkg::EV_W-1:0]          event_res,
	output logic                                   last_event
);

	localparam int SET_W   = (MAX_SET_COUNT > 1) ? $clog2(MAX_SET_COUNT) : 1;
	localparam int ENTRY_W = 1 + SET_W + ADDRESS_WIDTH;

	logic [slc_pkg::SET_BITS_W-1:0]   set_bits_q;
	logic [slc_pkg::BLOCK_BITS_W-1:0] block_bits_q;
	logic [slc_pkg::WAYS_W-1:0]       ways_q;
	logic                             flush;

	logic                             push;
	logic [ENTRY_W-1:0]               push_data;
	logic                             pop;
	logic [ENTRY_W-1:0]               pop_data;
	slc_pkg::q_stat_t                 q_stat;

	assign flush = cfg_we && (cfg_index == slc_pkg::REG_WAYS);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= '0;
			block_bits_q <= '0;
			ways_q       <= slc_pkg::WAYS_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				slc_pkg::REG_SET_BITS: begin
					set_bits_q <= cfg_data[slc_pkg::SET_BITS_W-1:0];
				end
				slc_pkg::REG_BLOCK_BITS: begin
					block_bits_q <= cfg_data[slc_pkg::BLOCK_BITS_W-1:0];
				end
				slc_pkg::REG_WAYS: begin
					ways_q <= cfg_data[slc_pkg::WAYS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	slc_front #(
		.MAX_SET_COUNT (MAX_SET_COUNT),
		.ADDRESS_WIDTH (ADDRESS_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.address    (address),
		.set_bits   (set_bits_q),
		.block_bits (block_bits_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_data  (push_data)
	);

	slc_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (slc_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	slc_back #(
		.MAX_SET_COUNT (MAX_SET_COUNT),
		.MAX_WAYS      (MAX_WAYS),
		.ADDRESS_WIDTH (ADDRESS_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ways_in_use (ways_q),
		.flush       (flush),
		.q_stat      (q_stat),
		.pop         (pop),
		.pop_data    (pop_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_res   (event_res),
		.last_event  (last_event)
	);

	// Queue never overruns or underruns; events of one access leave back to back
	`SLC_ASSERT_IMPLIES(a_push_not_full, clk, arst_n, push, !q_stat.full, "push into full queue")
	`SLC_ASSERT_IMPLIES(a_pop_not_empty, clk, arst_n, pop, !q_stat.empty, "pop from empty queue")
	`SLC_ASSERT_NEXT(a_events_contiguous, clk, arst_n, out_valid && !out_stall && !last_event, out_valid, "event group broken")

endmodule

`default_nettype wire
